// File: hdl/kldp_pkg.sv
// shared types and constants of the keypad level decoder
// no dependencies
package kldp_pkg;

    localparam int PAGES = 3;
    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    // configuration register indexes
    localparam logic [2:0] REG_NULL_LEVEL = 3'd0;
    localparam logic [2:0] REG_JITTER     = 3'd1;
    localparam logic [2:0] REG_DEBOUNCE   = 3'd2;
    localparam logic [2:0] REG_PAGE_LOW   = 3'd3;
    localparam logic [2:0] REG_PAGE_MID   = 3'd4;
    localparam logic [2:0] REG_PAGE_HIGH  = 3'd5;
    localparam logic [2:0] REG_BUTTONS    = 3'd6;

    // item kinds
    localparam logic [1:0] KIND_PAGE   = 2'd0;
    localparam logic [1:0] KIND_BUTTON = 2'd1;
    localparam logic [1:0] KIND_LEVEL  = 2'd2;
    localparam logic [1:0] KIND_ACTION = 2'd3;

    // actions
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_PLAY = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;

    // status codes
    localparam logic [2:0] ST_ACTED    = 3'd0;
    localparam logic [2:0] ST_NULL     = 3'd1;
    localparam logic [2:0] ST_DEBOUNCE = 3'd2;
    localparam logic [2:0] ST_NO_MATCH = 3'd3;
    localparam logic [2:0] ST_NO_FILE  = 3'd4;
    localparam logic [2:0] ST_BAD_PAGE = 3'd5;
    localparam logic [2:0] ST_PAGE_SET = 3'd6;
    localparam logic [2:0] ST_WRITTEN  = 3'd7;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_SCAN_RD  = 8'b0000_0100,
        S_SCAN_CMP = 8'b0000_1000,
        S_ACT_RD   = 8'b0001_0000,
        S_ACT_EVAL = 8'b0010_0000,
        S_MOD      = 8'b0100_0000,
        S_PLAY     = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] file_number;
        logic [3:0]  button_hit;
        logic [2:0]  status;
    } t_result;

    // |v - t| <= j without wrap
    function automatic logic near_level(input logic [10:0] v, input logic [10:0] t,
                                        input logic [10:0] j);
        logic [11:0] vj;
        logic [11:0] tj;
        vj = {1'b0, v} + {1'b0, j};
        tj = {1'b0, t} + {1'b0, j};
        return (vj >= {1'b0, t}) && ({1'b0, v} <= tj);
    endfunction

endpackage

// File: hdl/keypad_level_decoder_playlist.sv
// keypad level decoder with per-button playlists, top level
// depends on kldp_pkg
//
// Takes one item at a time and returns exactly one result item for each.
// Page samples and table writes are decided in the decode state. A button
// sample scans the level table one entry at a time (a memory read state,
// then a compare state); a match then reads the action entry and evaluates
// it. A shuffle entry with a nonempty range then runs a 32-step restoring
// remainder unit, one quotient bit per cycle. The input side is not ready
// while an item is at work; a result sits in an output register and the
// next item may be taken while it waits.
// The level and action tables hold garbage until written; the per-entry file
// counters read as zero after reset through valid bits, no clearing pass.
module keypad_level_decoder_playlist #(
    parameter int BUTTONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // sample[10:0] now_ms[42:11] slot[46:43] page_slot[48:47] level[59:49]
    // file_start[75:60] file_end[91:76] shuffle[92] stop_only[93]
    input  logic [95:0] i_s_tdata,
    // kind[1:0]
    input  logic [1:0]  i_s_tuser,
    // result output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // action[1:0] file_number[17:2] page_now[19:18] button_hit[23:20]
    output logic [23:0] o_m_tdata,
    // status[2:0]
    output logic [2:0]  o_m_tuser,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW      = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int CW      = $clog2(BUTTONS + 1);
    localparam int ENTRIES = kldp_pkg::PAGES * BUTTONS;
    localparam int EW      = $clog2(ENTRIES);

    // configuration registers
    logic [10:0] r_null, r_jit, r_plow, r_pmid, r_phigh;
    logic [15:0] r_deb;
    logic [4:0]  r_biu;
    logic        w_cfg_wr;
    logic [2:0]  w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[4:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_null  <= 11'd0;
            r_jit   <= 11'd8;
            r_deb   <= 16'd250;
            r_plow  <= 11'd0;
            r_pmid  <= 11'd1024;
            r_phigh <= 11'd2047;
            r_biu   <= 5'd15;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                kldp_pkg::REG_NULL_LEVEL: r_null  <= pwdata[10:0];
                kldp_pkg::REG_JITTER:     r_jit   <= pwdata[10:0];
                kldp_pkg::REG_DEBOUNCE:   r_deb   <= pwdata[15:0];
                kldp_pkg::REG_PAGE_LOW:   r_plow  <= pwdata[10:0];
                kldp_pkg::REG_PAGE_MID:   r_pmid  <= pwdata[10:0];
                kldp_pkg::REG_PAGE_HIGH:  r_phigh <= pwdata[10:0];
                kldp_pkg::REG_BUTTONS:    r_biu   <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            kldp_pkg::REG_NULL_LEVEL: prdata = {21'd0, r_null};
            kldp_pkg::REG_JITTER:     prdata = {21'd0, r_jit};
            kldp_pkg::REG_DEBOUNCE:   prdata = {16'd0, r_deb};
            kldp_pkg::REG_PAGE_LOW:   prdata = {21'd0, r_plow};
            kldp_pkg::REG_PAGE_MID:   prdata = {21'd0, r_pmid};
            kldp_pkg::REG_PAGE_HIGH:  prdata = {21'd0, r_phigh};
            kldp_pkg::REG_BUTTONS:    prdata = {27'd0, r_biu};
            default:                  prdata = 32'd0;
        endcase
    end

    // latched item
    logic [1:0]  r_kind;
    logic [10:0] r_sample, r_level;
    logic [31:0] r_now;
    logic [3:0]  r_slot;
    logic [1:0]  r_pslot;
    logic [15:0] r_fstart, r_fend;
    logic        r_shuf, r_stop;

    // sequencer and working state
    kldp_pkg::t_state r_state, n_state;
    logic [1:0]       r_page, n_page;
    logic [31:0]      r_last, n_last;
    logic [31:0]      r_rand, n_rand;
    logic [CW-1:0]    r_idx, n_idx;
    logic [EW-1:0]    r_ent, n_ent;
    logic [LW-1:0]    r_hit, n_hit;
    logic [15:0]      r_cur, n_cur;
    logic [15:0]      r_start, n_start;
    logic [31:0]      r_dvd, n_dvd;
    logic [16:0]      r_rem, n_rem;
    logic [15:0]      r_dvs, n_dvs;
    logic [5:0]       r_step, n_step;
    kldp_pkg::t_result r_res, n_res;
    logic             r_res_vld, n_res_vld;

    // output register
    logic             r_out_vld;
    kldp_pkg::t_result r_out;
    logic [1:0]       r_out_page;

    // memories
    logic [10:0]      level_mem [BUTTONS];
    logic [33:0]      action_mem [ENTRIES];
    logic [15:0]      nf_mem [ENTRIES];
    logic [10:0]      r_lvl_rd;
    logic [33:0]      r_act_rd;
    logic [15:0]      r_nf_rd;
    logic [ENTRIES-1:0] r_nfv;

    logic             w_lvl_we, w_act_we, w_nf_we;
    logic [EW-1:0]    w_wr_ent, w_nf_addr;
    logic [15:0]      w_nf_data;

    logic             w_in_acc, w_out_acc;
    logic [6:0]       w_count;
    logic             w_slot_ok, w_pslot_ok;
    logic [15:0]      w_nf_cur;
    logic [16:0]      w_trial;
    logic [31:0]      w_lfsr;

    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign w_out_acc = r_out_vld && i_m_tready;
    // ready only when idle and no result is still waiting for the output register
    assign o_s_tready = (r_state == kldp_pkg::S_IDLE) && !r_res_vld;

    // searched entries, capped at the table depth
    assign w_count = ({2'd0, r_biu} > 7'(BUTTONS)) ? 7'(BUTTONS) : {2'd0, r_biu};
    assign w_slot_ok  = ({3'd0, r_slot} < 7'(BUTTONS));
    assign w_pslot_ok = (32'(r_pslot) < 32'(kldp_pkg::PAGES));
    assign w_wr_ent   = EW'(r_pslot) * EW'(BUTTONS) + EW'(LW'(r_slot));
    assign w_nf_cur   = r_nfv[r_ent] ? r_nf_rd : 16'd0;
    assign w_trial    = {r_rem[15:0], r_dvd[31]} - {1'b0, r_dvs};
    assign w_lfsr     = r_rand[0] ? ((r_rand >> 1) ^ kldp_pkg::LFSR_MASK) : (r_rand >> 1);

    assign w_lvl_we  = (r_state == kldp_pkg::S_DECODE) && (r_kind == kldp_pkg::KIND_LEVEL)
                       && w_slot_ok;
    assign w_act_we  = (r_state == kldp_pkg::S_DECODE) && (r_kind == kldp_pkg::KIND_ACTION)
                       && w_slot_ok && w_pslot_ok;
    assign w_nf_we   = w_act_we || (r_state == kldp_pkg::S_PLAY);
    assign w_nf_addr = w_act_we ? w_wr_ent : r_ent;
    assign w_nf_data = w_act_we ? 16'd0 : r_cur + 16'd1;

    always_ff @(posedge i_clk) begin
        if (w_lvl_we) begin
            level_mem[LW'(r_slot)] <= r_level;
        end
        r_lvl_rd <= level_mem[r_idx[LW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_act_we) begin
            action_mem[w_wr_ent] <= {r_stop, r_shuf, r_fend, r_fstart};
        end
        r_act_rd <= action_mem[r_ent];
    end

    always_ff @(posedge i_clk) begin
        if (w_nf_we) begin
            nf_mem[w_nf_addr] <= w_nf_data;
        end
        r_nf_rd <= nf_mem[r_ent];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nfv <= '0;
        end else if (w_nf_we) begin
            r_nfv[w_nf_addr] <= 1'b1;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind   <= i_s_tuser;
            r_sample <= i_s_tdata[10:0];
            r_now    <= i_s_tdata[42:11];
            r_slot   <= i_s_tdata[46:43];
            r_pslot  <= i_s_tdata[48:47];
            r_level  <= i_s_tdata[59:49];
            r_fstart <= i_s_tdata[75:60];
            r_fend   <= i_s_tdata[91:76];
            r_shuf   <= i_s_tdata[92];
            r_stop   <= i_s_tdata[93];
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_page    = r_page;
        n_last    = r_last;
        n_rand    = r_rand;
        n_idx     = r_idx;
        n_ent     = r_ent;
        n_hit     = r_hit;
        n_cur     = r_cur;
        n_start   = r_start;
        n_dvd     = r_dvd;
        n_rem     = r_rem;
        n_dvs     = r_dvs;
        n_step    = r_step;
        n_res     = r_res;
        n_res_vld = r_res_vld;

        case (r_state)
            kldp_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = kldp_pkg::S_DECODE;
                end
            end
            kldp_pkg::S_DECODE: begin
                n_res     = '{action: kldp_pkg::ACT_NONE, file_number: 16'd0,
                              button_hit: 4'd0, status: kldp_pkg::ST_WRITTEN};
                n_res_vld = 1'b1;
                n_state   = kldp_pkg::S_IDLE;
                n_idx     = '0;
                case (r_kind)
                    kldp_pkg::KIND_PAGE: begin
                        n_res.status = kldp_pkg::ST_PAGE_SET;
                        if (kldp_pkg::near_level(r_sample, r_plow, r_jit)) begin
                            n_page = 2'd0;
                        end else if (kldp_pkg::near_level(r_sample, r_pmid, r_jit)) begin
                            n_page = 2'd1;
                        end else if (kldp_pkg::near_level(r_sample, r_phigh, r_jit)) begin
                            n_page = 2'd2;
                        end else begin
                            n_res.status = kldp_pkg::ST_BAD_PAGE;
                        end
                    end
                    kldp_pkg::KIND_BUTTON: begin
                        if (kldp_pkg::near_level(r_sample, r_null, r_jit)) begin
                            n_res.status = kldp_pkg::ST_NULL;
                        end else if ((r_now - r_last) < {16'd0, r_deb}) begin
                            n_res.status = kldp_pkg::ST_DEBOUNCE;
                        end else begin
                            n_last = r_now;
                            if (w_count == 7'd0) begin
                                n_res.status = kldp_pkg::ST_NO_MATCH;
                            end else begin
                                n_res_vld = 1'b0;
                                n_state   = kldp_pkg::S_SCAN_RD;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            kldp_pkg::S_SCAN_RD: begin
                n_state = kldp_pkg::S_SCAN_CMP;
            end
            kldp_pkg::S_SCAN_CMP: begin
                if (kldp_pkg::near_level(r_sample, r_lvl_rd, r_jit)) begin
                    n_hit   = r_idx[LW-1:0];
                    n_ent   = EW'(r_page) * EW'(BUTTONS) + EW'(r_idx[LW-1:0]);
                    n_state = kldp_pkg::S_ACT_RD;
                end else if (7'(r_idx) + 7'd1 >= w_count) begin
                    n_res     = '{action: kldp_pkg::ACT_NONE, file_number: 16'd0,
                                  button_hit: 4'd0, status: kldp_pkg::ST_NO_MATCH};
                    n_res_vld = 1'b1;
                    n_state   = kldp_pkg::S_IDLE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = kldp_pkg::S_SCAN_RD;
                end
            end
            kldp_pkg::S_ACT_RD: begin
                n_state = kldp_pkg::S_ACT_EVAL;
            end
            kldp_pkg::S_ACT_EVAL: begin
                n_start = r_act_rd[15:0];
                n_res   = '{action: kldp_pkg::ACT_NONE, file_number: 16'd0,
                            button_hit: 4'(r_hit), status: kldp_pkg::ST_ACTED};
                if (r_act_rd[33]) begin
                    n_res.action = kldp_pkg::ACT_STOP;
                    n_res_vld    = 1'b1;
                    n_state      = kldp_pkg::S_IDLE;
                end else if (r_act_rd[15:0] == 16'd0) begin
                    n_res.status = kldp_pkg::ST_NO_FILE;
                    n_res_vld    = 1'b1;
                    n_state      = kldp_pkg::S_IDLE;
                end else if (r_act_rd[32] && (r_act_rd[31:16] > r_act_rd[15:0])) begin
                    n_rand  = w_lfsr;
                    n_dvd   = w_lfsr;
                    n_dvs   = r_act_rd[31:16] - r_act_rd[15:0];
                    n_rem   = 17'd0;
                    n_step  = 6'd32;
                    n_state = kldp_pkg::S_MOD;
                end else if (r_act_rd[32]) begin
                    n_cur   = r_act_rd[15:0];
                    n_state = kldp_pkg::S_PLAY;
                end else begin
                    if ((w_nf_cur == 16'd0) || (w_nf_cur > r_act_rd[31:16])) begin
                        n_cur = r_act_rd[15:0];
                    end else begin
                        n_cur = w_nf_cur;
                    end
                    n_state = kldp_pkg::S_PLAY;
                end
            end
            kldp_pkg::S_MOD: begin
                // one restoring remainder step per cycle
                if (w_trial[16]) begin
                    n_rem = {r_rem[15:0], r_dvd[31]};
                end else begin
                    n_rem = w_trial;
                end
                n_dvd  = {r_dvd[30:0], 1'b0};
                n_step = r_step - 6'd1;
                if (r_step == 6'd1) begin
                    n_cur   = r_start + n_rem[15:0];
                    n_state = kldp_pkg::S_PLAY;
                end
            end
            kldp_pkg::S_PLAY: begin
                n_res.action      = kldp_pkg::ACT_PLAY;
                n_res.file_number = r_cur;
                n_res_vld         = 1'b1;
                n_state           = kldp_pkg::S_IDLE;
            end
            default: n_state = kldp_pkg::S_IDLE;
        endcase

        // pending result moves into the output register when it is free
        if (r_res_vld && (!r_out_vld || i_m_tready)) begin
            n_res_vld = 1'b0;
        end
    end

    // a new item is accepted only after its predecessor's result has moved out
    logic w_hold;
    assign w_hold = r_res_vld && r_out_vld && !i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kldp_pkg::S_IDLE;
            r_page    <= 2'd0;
            r_last    <= 32'd0;
            r_rand    <= 32'd1;
            r_res_vld <= 1'b0;
        end else if (!(w_hold && r_state == kldp_pkg::S_IDLE)) begin
            r_state   <= n_state;
            r_page    <= n_page;
            r_last    <= n_last;
            r_rand    <= n_rand;
            r_res_vld <= n_res_vld;
        end else begin
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_ent   <= n_ent;
        r_hit   <= n_hit;
        r_cur   <= n_cur;
        r_start <= n_start;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_dvs   <= n_dvs;
        r_step  <= n_step;
        if (!(r_res_vld && !(!r_out_vld || i_m_tready))) begin
            r_res <= n_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_res_vld && (!r_out_vld || i_m_tready)) begin
            r_out_vld <= 1'b1;
        end else if (w_out_acc) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_res_vld && (!r_out_vld || i_m_tready)) begin
            r_out      <= r_res;
            r_out_page <= r_page;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out.button_hit, r_out_page, r_out.file_number, r_out.action};
    assign o_m_tuser  = r_out.status;

    // checks
    a_acted_has_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_out.status == kldp_pkg::ST_ACTED) ==
                       (r_out.action != kldp_pkg::ACT_NONE)))
        else $error("status and action disagree");

    a_file_only_on_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.action != kldp_pkg::ACT_PLAY) |-> (r_out.file_number == 16'd0))
        else $error("file number without play");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_s_tready)
        else $error("second item taken while one is at work");

    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kldp_pkg::S_MOD) |-> (r_dvs != 16'd0))
        else $error("remainder unit started with zero span");

    a_result_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_out_vld && !i_m_tready) |=> r_res_vld)
        else $error("pending result dropped");

endmodule

// File: tb/keypad_level_decoder_playlist_tb.sv
// testbench of the keypad level decoder with per-button playlists
// depends on kldp_pkg and keypad_level_decoder_playlist; self-checking, no files read
// drives items on the stream input, predicts every result and compares field by field
module keypad_level_decoder_playlist_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUTTONS   = 16;
    localparam int ENTRIES   = kldp_pkg::PAGES * BUTTONS;
    localparam int IDLE_LIMIT = 5000;   // cycles with no handshake before giving up
    localparam int SETTLE    = 100;     // cycles allowed after the last result
    localparam int HOLD_CYCLES = 400;   // length of the long receiver hold-off

    // one input item, unpacked
    typedef struct {
        logic [1:0]  kind;
        logic [10:0] sample;
        logic [31:0] now_ms;
        logic [3:0]  slot;
        logic [1:0]  page_slot;
        logic [10:0] level;
        logic [15:0] file_start;
        logic [15:0] file_end;
        logic        shuffle;
        logic        stop_only;
    } t_key_item;

    // one decoded result
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] file_number;
        logic [1:0]  page_now;
        logic [3:0]  button_hit;
        logic [2:0]  status;
    } t_decode;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [95:0] i_s_tdata;    // sample now_ms slot page_slot level file_start file_end shuffle stop
    logic [1:0]  i_s_tuser;    // kind
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;    // action file_number page_now button_hit
    logic [2:0]  o_m_tuser;    // status
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    keypad_level_decoder_playlist #(.BUTTONS(BUTTONS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 i_clk = ~i_clk;

    // mirror of the decoder state
    logic [10:0] cfg_null, cfg_jitter, cfg_page_low, cfg_page_mid, cfg_page_high;
    logic [15:0] cfg_debounce;
    logic [4:0]  cfg_buttons;
    logic [1:0]  page_cur;
    logic [31:0] last_accept;
    logic [31:0] lfsr;
    logic [10:0] level_tbl [BUTTONS];
    logic [33:0] action_tbl [ENTRIES];
    logic [15:0] file_cnt [ENTRIES];

    t_decode     expected_results[$];

    // stimulus knobs and bookkeeping
    int          idle_pct;
    int          stall_pct;
    int          hold_req = 0;      // bumped by a test to ask for one long hold-off
    int          hold_ack = 0;
    int          hold_left = 0;
    logic [31:0] clock_ms;
    int          mismatches = 0;
    int          items_sent;
    int          quiet_cycles = 0;

    // |v - t| <= j, no wrap
    function automatic bit within_jitter(logic [10:0] v, logic [10:0] t);
        int unsigned vi, ti, ji;
        vi = 32'(v);
        ti = 32'(t);
        ji = 32'(cfg_jitter);
        return (vi + ji >= ti) && (vi <= ti + ji);
    endfunction

    function automatic t_decode mk(logic [1:0] act, logic [15:0] f, logic [3:0] h,
                                   logic [2:0] st);
        t_decode r;
        r.action      = act;
        r.file_number = f;
        r.page_now    = page_cur;
        r.button_hit  = h;
        r.status      = st;
        return r;
    endfunction

    // advance the decoder mirror by one item and return its result
    function automatic t_decode decode_item(t_key_item it);
        int          count, hit, e;
        logic [15:0] fs, fe, cur;
        logic [31:0] span, pick;
        bit          found;
        hit   = 0;
        found = 0;
        case (it.kind)
            kldp_pkg::KIND_PAGE: begin
                if (within_jitter(it.sample, cfg_page_low))       page_cur = 2'd0;
                else if (within_jitter(it.sample, cfg_page_mid))  page_cur = 2'd1;
                else if (within_jitter(it.sample, cfg_page_high)) page_cur = 2'd2;
                else return mk(kldp_pkg::ACT_NONE, 16'd0, 4'd0, kldp_pkg::ST_BAD_PAGE);
                return mk(kldp_pkg::ACT_NONE, 16'd0, 4'd0, kldp_pkg::ST_PAGE_SET);
            end
            kldp_pkg::KIND_LEVEL: begin
                level_tbl[it.slot] = it.level;
                return mk(kldp_pkg::ACT_NONE, 16'd0, 4'd0, kldp_pkg::ST_WRITTEN);
            end
            kldp_pkg::KIND_ACTION: begin
                if (int'(it.page_slot) < kldp_pkg::PAGES) begin
                    e = int'(it.page_slot) * BUTTONS + int'(it.slot);
                    action_tbl[e] = {it.stop_only, it.shuffle, it.file_end, it.file_start};
                    file_cnt[e]   = 16'd0;
                end
                return mk(kldp_pkg::ACT_NONE, 16'd0, 4'd0, kldp_pkg::ST_WRITTEN);
            end
            default: begin
                if (within_jitter(it.sample, cfg_null))
                    return mk(kldp_pkg::ACT_NONE, 16'd0, 4'd0, kldp_pkg::ST_NULL);
                if (it.now_ms - last_accept < {16'd0, cfg_debounce})
                    return mk(kldp_pkg::ACT_NONE, 16'd0, 4'd0, kldp_pkg::ST_DEBOUNCE);
                last_accept = it.now_ms;
                count = (int'(cfg_buttons) > BUTTONS) ? BUTTONS : int'(cfg_buttons);
                for (int i = 0; i < count; i++) begin
                    if (!found && within_jitter(it.sample, level_tbl[i])) begin
                        hit   = i;
                        found = 1;
                    end
                end
                if (!found)
                    return mk(kldp_pkg::ACT_NONE, 16'd0, 4'd0, kldp_pkg::ST_NO_MATCH);
                e  = int'(page_cur) * BUTTONS + hit;
                fs = action_tbl[e][15:0];
                fe = action_tbl[e][31:16];
                // stop wins over every other field of the entry
                if (action_tbl[e][33])
                    return mk(kldp_pkg::ACT_STOP, 16'd0, hit[3:0], kldp_pkg::ST_ACTED);
                if (fs == 16'd0)
                    return mk(kldp_pkg::ACT_NONE, 16'd0, hit[3:0], kldp_pkg::ST_NO_FILE);
                if (action_tbl[e][32]) begin
                    if (fe > fs) begin
                        // galois lfsr step, then a pick inside the range
                        lfsr = lfsr[0] ? ((lfsr >> 1) ^ kldp_pkg::LFSR_MASK) : (lfsr >> 1);
                        span = 32'(fe) - 32'(fs);
                        pick = lfsr % span;
                        file_cnt[e] = fs + pick[15:0];
                    end else begin
                        file_cnt[e] = fs;
                    end
                end
                cur = file_cnt[e];
                if (cur == 16'd0 || cur > fe)
                    cur = fs;
                file_cnt[e] = cur + 16'd1;
                return mk(kldp_pkg::ACT_PLAY, cur, hit[3:0], kldp_pkg::ST_ACTED);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // receiver: random stalls, or a long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack   <= hold_req;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // result checker: every result against the oldest expectation
    always @(posedge i_clk) begin
        t_decode want, got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.action      = o_m_tdata[1:0];
            got.file_number = o_m_tdata[17:2];
            got.page_now    = o_m_tdata[19:18];
            got.button_hit  = o_m_tdata[23:20];
            got.status      = o_m_tuser;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: act %0d file %0d page %0d hit %0d st %0d",
                             got.action, got.file_number, got.page_now, got.button_hit,
                             got.status);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected act %0d file %0d page %0d hit %0d ",
                                  "st %0d, got act %0d file %0d page %0d hit %0d st %0d"},
                                 want.action, want.file_number, want.page_now,
                                 want.button_hit, want.status, got.action,
                                 got.file_number, got.page_now, got.button_hit,
                                 got.status);
                end
            end
        end
    end

    // watchdog: cycles in a row with no handshake anywhere
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (psel && penable) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired, %0d results still outstanding",
                     expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // send one item, wait for acceptance, then record its expected result
    task automatic send_item(t_key_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.kind;
        i_s_tdata  <= {2'b00, it.stop_only, it.shuffle, it.file_end, it.file_start,
                       it.level, it.page_slot, it.slot, it.now_ms, it.sample};
        do @(posedge i_clk); while (!o_s_tready);
        expected_results.push_back(decode_item(it));
        items_sent++;
    endtask

    // all results in and the block quiet again
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            kldp_pkg::REG_NULL_LEVEL: cfg_null      = val[10:0];
            kldp_pkg::REG_JITTER:     cfg_jitter    = val[10:0];
            kldp_pkg::REG_DEBOUNCE:   cfg_debounce  = val[15:0];
            kldp_pkg::REG_PAGE_LOW:   cfg_page_low  = val[10:0];
            kldp_pkg::REG_PAGE_MID:   cfg_page_mid  = val[10:0];
            kldp_pkg::REG_PAGE_HIGH:  cfg_page_high = val[10:0];
            default:                  cfg_buttons   = val[4:0];
        endcase
    endtask

    task automatic set_all(int nl, int jt, int db, int lo, int md, int hi, int nb);
        write_reg(kldp_pkg::REG_NULL_LEVEL, 32'(nl));
        write_reg(kldp_pkg::REG_JITTER, 32'(jt));
        write_reg(kldp_pkg::REG_DEBOUNCE, 32'(db));
        write_reg(kldp_pkg::REG_PAGE_LOW, 32'(lo));
        write_reg(kldp_pkg::REG_PAGE_MID, 32'(md));
        write_reg(kldp_pkg::REG_PAGE_HIGH, 32'(hi));
        write_reg(kldp_pkg::REG_BUTTONS, 32'(nb));
    endtask

    // item with every field random, kind chosen by the caller
    function automatic t_key_item noise(logic [1:0] k);
        t_key_item it;
        it.kind       = k;
        it.sample     = 11'($urandom);
        it.now_ms     = $urandom;
        it.slot       = 4'($urandom);
        it.page_slot  = 2'($urandom);
        it.level      = 11'($urandom);
        it.file_start = 16'($urandom);
        it.file_end   = 16'($urandom);
        it.shuffle    = 1'($urandom);
        it.stop_only  = 1'($urandom);
        return it;
    endfunction

    task automatic put_level(int slot, int lvl);
        t_key_item it;
        it = noise(kldp_pkg::KIND_LEVEL);
        it.slot  = 4'(slot);
        it.level = 11'(lvl);
        send_item(it);
    endtask

    task automatic put_action(int pg, int slot, int fs, int fe, bit shuf, bit stp);
        t_key_item it;
        it = noise(kldp_pkg::KIND_ACTION);
        it.page_slot  = 2'(pg);
        it.slot       = 4'(slot);
        it.file_start = 16'(fs);
        it.file_end   = 16'(fe);
        it.shuffle    = shuf;
        it.stop_only  = stp;
        send_item(it);
    endtask

    task automatic press(int lvl, logic [31:0] at);
        t_key_item it;
        it = noise(kldp_pkg::KIND_BUTTON);
        it.sample = 11'(lvl);
        it.now_ms = at;
        send_item(it);
    endtask

    task automatic page_sample(int lvl);
        t_key_item it;
        it = noise(kldp_pkg::KIND_PAGE);
        it.sample = 11'(lvl);
        send_item(it);
    endtask

    // a level close to one target, clipped to the field range
    function automatic int near(int target);
        int v;
        v = target + int'($urandom_range(2 * cfg_jitter)) - int'(cfg_jitter);
        if (v < 0)    v = 0;
        if (v > 2047) v = 2047;
        return v;
    endfunction

    // random action entry: mostly short playlists, some stop and empty ones
    task automatic random_action(int pg, int slot);
        int fs, fe, r, d;
        r  = $urandom_range(99);
        fs = (r < 10) ? 0 : $urandom_range(65535, 1);
        d  = $urandom_range(6);
        if ($urandom_range(3) == 0)
            fe = $urandom;
        else
            fe = (fs + d > 65535) ? 65535 : fs + d;
        put_action(pg, slot, fs, fe, $urandom_range(2) == 0, r >= 90);
    endtask

    // ---------------------------------------------------------------------
    // tables: every level and every action entry written before any press
    task automatic test_table_load();
        put_level(14, 0);          // level extreme, replaced below
        for (int i = 0; i < BUTTONS; i++)
            put_level(i, (i == BUTTONS - 1) ? 2047 : 100 + 120 * i);
        for (int p = 0; p < kldp_pkg::PAGES; p++)
            for (int s = 0; s < BUTTONS; s++)
                random_action(p, s);
        // page slot past the last page is dropped but still acknowledged
        put_action(3, 5, 1, 2, 1'b0, 1'b0);
        drain();
    endtask

    // page samples at the levels, between them and at the field extremes
    task automatic test_page_select();
        page_sample(0);
        page_sample(2047);
        page_sample(1024 + 8);
        page_sample(500);          // matches no page level, page kept
        page_sample(2047 - 9);
        page_sample(0);
        drain();
    endtask

    // directed presses on page 0: stop, empty, playlist wrap, shuffle
    task automatic test_button_cases();
        put_action(0, 1, 0, 0, 1'b1, 1'b1);            // stop wins over everything
        put_action(0, 2, 0, 5, 1'b0, 1'b0);            // no file mapped
        put_action(0, 3, 10, 12, 1'b0, 1'b0);          // plain playlist
        put_action(0, 4, 65535, 65535, 1'b0, 1'b0);    // counter wraps past 16 bits
        put_action(0, 5, 40, 30, 1'b1, 1'b0);          // shuffle with empty range
        put_action(0, 6, 1, 65535, 1'b1, 1'b0);        // shuffle over a wide range
        clock_ms = 32'hFFFF_FF00;
        press(0, clock_ms + 1000);                     // null level
        clock_ms += 1000;
        press(220, clock_ms);                          // slot 1: stop
        press(340, clock_ms + 10);                     // inside debounce window
        clock_ms += 300;                               // already past the 32-bit wrap
        press(340, clock_ms);
        for (int i = 0; i < 4; i++) begin
            clock_ms += 250;                           // exactly the window
            press(460, clock_ms);
        end
        for (int i = 0; i < 3; i++) begin
            clock_ms += 251;
            press(580, clock_ms);
        end
        clock_ms += 400;
        press(700, clock_ms);
        clock_ms += 400;
        press(820, clock_ms);
        clock_ms += 400;
        press(2047, clock_ms);                         // last slot, outside the search
        drain();
    endtask

    // random mix: mostly presses near table levels with passing time
    task automatic test_random_traffic(int n);
        t_key_item it;
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 70) begin
                it = noise(kldp_pkg::KIND_BUTTON);
                r  = $urandom_range(99);
                if (r < 80)      clock_ms += 32'(cfg_debounce) + $urandom_range(40);
                else if (r < 95) clock_ms += $urandom_range(cfg_debounce);
                else             clock_ms = $urandom;
                it.now_ms = clock_ms;
                if ($urandom_range(9) != 0)
                    it.sample = 11'(near(int'(level_tbl[$urandom_range(BUTTONS - 1)])));
            end else if (r < 80) begin
                it = noise(kldp_pkg::KIND_PAGE);
                case ($urandom_range(3))
                    0: it.sample = 11'(near(int'(cfg_page_low)));
                    1: it.sample = 11'(near(int'(cfg_page_mid)));
                    2: it.sample = 11'(near(int'(cfg_page_high)));
                    default: ;
                endcase
            end else if (r < 88) begin
                it = noise(kldp_pkg::KIND_LEVEL);
            end else begin
                it = noise(kldp_pkg::KIND_ACTION);
                if ($urandom_range(1))
                    it.file_end = (it.file_start > 65530) ? 16'hFFFF
                                  : 16'(32'(it.file_start) + $urandom_range(5));
            end
            send_item(it);
        end
        drain();
    endtask

    // register settings, extremes among them, traffic after all but the last, which restores the reset values
    task automatic test_config_sweep();
        set_all(2047, 0, 0, 2047, 0, 1024, 16);
        test_random_traffic(30);
        set_all(0, 2047, 65535, 0, 2047, 0, 0);
        test_random_traffic(20);
        set_all(1, 20, 10, 300, 900, 1700, 7);
        test_random_traffic(30);
        set_all(0, 8, 250, 0, 1024, 2047, 15);
        drain();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_req++;
        test_random_traffic(20);
    endtask

    // ---------------------------------------------------------------------
    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= kldp_pkg::KIND_PAGE;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        idle_pct   = 0;
        stall_pct  = 0;
        items_sent = 0;
        clock_ms   = 0;
        // mirror reset
        cfg_null = 11'd0;  cfg_jitter = 11'd8;  cfg_debounce = 16'd250;
        cfg_page_low = 11'd0;  cfg_page_mid = 11'd1024;  cfg_page_high = 11'd2047;
        cfg_buttons = 5'd15;
        page_cur = 2'd0;  last_accept = 32'd0;  lfsr = 32'd1;
        foreach (file_cnt[i]) file_cnt[i] = 16'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_load();
        test_page_select();
        test_button_cases();
        test_config_sweep();

        // idle and stall phases over the random part
        idle_pct = 0;   stall_pct = 0;   test_random_traffic(110);
        idle_pct = 69;  stall_pct = 0;   test_random_traffic(110);
        idle_pct = 0;   stall_pct = 69;  test_random_traffic(110);
        idle_pct = 32;  stall_pct = 32;  test_random_traffic(110);
        test_backpressure();
        drain();

        $display("covered %0d items: tables, page select, stop/empty/playlist/shuffle presses,",
                 items_sent);
        $display("register sweep with extremes, idle and stall phases, long output hold-off");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: keypad_level_decoder_playlist.f
hdl/kldp_pkg.sv
hdl/keypad_level_decoder_playlist.sv
tb/keypad_level_decoder_playlist_tb.sv
